// ===== src/aligned_bump_allocator_with_overflow_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the aligned bump allocator
// Shared helpers that clock on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_BUMP_ALLOCATOR_WITH_OVERFLOW_DEFINES_SVH
`define ALIGNED_BUMP_ALLOCATOR_WITH_OVERFLOW_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABAO_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aligned bump allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define ABAO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aligned bump allocator check failed");

`endif

// ===== src/abao_pkg.sv =====
// ----------------------------------------------------------------------------
// abao_pkg
// Constants, types and helpers shared by the bump allocator and its memory.
// ----------------------------------------------------------------------------
package abao_pkg;

  localparam int unsigned MAX_CHUNKS = 8;
  localparam int unsigned IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned REGION_W   = 4;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [31:0] DEFAULT_ALIGN_MASK = 32'h0000_000F;
  localparam logic [31:0] CHUNK_GRAIN_MASK   = 32'h0000_FFFF;
  localparam logic [31:0] DEFAULT_BASE       = 32'h0010_0000;

  // Register index as seen on paddr[2].
  localparam logic REG_BASE_SIZE = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAIN_AL,
    ST_MAIN_CK,
    ST_RD,
    ST_CH_AL,
    ST_CH_CK,
    ST_OPEN
  } state_e;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
  } chunk_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    chunk_entry_t     data;
  } chunk_wr_t;

  // Round v up with the given low-bit mask, keeping the carry in bit 32.
  function automatic logic [32:0] align_up(logic [31:0] v, logic [31:0] m);
    logic [32:0] s;
    s = {1'b0, v} + {1'b0, m};
    return s & {1'b1, ~m};
  endfunction

endpackage

// ===== src/aligned_bump_allocator_with_overflow.sv =====
// ----------------------------------------------------------------------------
// aligned_bump_allocator_with_overflow
// Per-frame linear allocator with a main region and overflow chunks.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken when start is high and busy is low. An
// allocate beat aligns the main offset and grants space there if it fits;
// otherwise the open overflow chunks are tried in order, and if none fits a
// new chunk is opened, or table_full is set if the table is full. A reset
// beat empties the main region and closes all chunks. Every beat gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it. A reset beat or a zero size gives its result in the cycle after
// the accepting edge. An allocate beat steps through ST_MAIN_AL, ST_MAIN_CK,
// then ST_RD, ST_CH_AL and ST_CH_CK per chunk tried, and ST_OPEN when a chunk
// is opened; done is registered from the last. Each chunk entry takes a read
// of the chunk memory, an align step and a fit compare on one shared
// comparator. busy stays high for the whole scan; the next beat may start in
// the done cycle. After reset base_size is 1 MiB, the main region is empty and
// no chunk is open. The base_size register sits on the APB port at address 0;
// writing zero restores the default.
// ----------------------------------------------------------------------------
`include "aligned_bump_allocator_with_overflow_defines.svh"

module aligned_bump_allocator_with_overflow
  import abao_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [31:0]         request_size_i,
  input  logic [31:0]         alignment_i,
  output logic                done_o,
  output logic                granted_o,
  output logic [REGION_W-1:0] region_o,
  output logic [31:0]         grant_offset_o,
  output logic                opened_chunk_o,
  output logic [31:0]         opened_size_o,
  output logic                table_full_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_e              state_q, state_d;
  logic [31:0]         base_size_q;
  logic [31:0]         main_offset_q, main_offset_d;
  logic [CNT_W-1:0]    chunk_count_q, chunk_count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [31:0]         size_q, size_d;
  logic [31:0]         mask_q, mask_d;
  logic [32:0]         al_q, al_d;

  logic                done_q, done_d;
  logic                granted_q, granted_d;
  logic [REGION_W-1:0] region_q, region_d;
  logic [31:0]         grant_offset_q, grant_offset_d;
  logic                opened_q, opened_d;
  logic [31:0]         opened_size_q, opened_size_d;
  logic                table_full_q, table_full_d;

  chunk_wr_t           wr;
  chunk_entry_t        rd_entry;

  logic [31:0]         align_src;
  logic [32:0]         aligned;
  logic [33:0]         fit_sum;
  logic [31:0]         limit;
  logic                fit;
  logic [32:0]         cs_raw;
  logic [31:0]         cs;
  logic                last_chunk;
  logic [CNT_W-1:0]    count_inc;
  logic                cfg_wr;

  abao_chunk_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_entry)
  );

  // Shared align unit and fit comparator for the main region and the chunks.
  assign align_src  = (state_q == ST_MAIN_AL) ? main_offset_q : rd_entry.offset;
  assign aligned    = align_up(align_src, mask_q);
  assign fit_sum    = {1'b0, al_q} + {2'b00, size_q};
  assign limit      = (state_q == ST_MAIN_CK) ? base_size_q : rd_entry.size;
  assign fit        = (fit_sum <= {2'b00, limit});

  // New chunk size: request rounded to 64 KiB, at least base_size, saturated.
  assign cs_raw     = align_up(size_q, CHUNK_GRAIN_MASK);
  assign cs         = (cs_raw < {1'b0, base_size_q}) ? base_size_q :
                      (cs_raw[32] ? 32'hFFFF_FFFF : cs_raw[31:0]);

  assign count_inc  = chunk_count_q + CNT_W'(1);
  assign last_chunk = ((CNT_W'(idx_q) + CNT_W'(1)) == chunk_count_q);

  assign busy       = (state_q != ST_IDLE);

  always_comb begin
    state_d        = state_q;
    main_offset_d  = main_offset_q;
    chunk_count_d  = chunk_count_q;
    idx_d          = idx_q;
    size_d         = size_q;
    mask_d         = mask_q;
    al_d           = al_q;
    done_d         = 1'b0;
    granted_d      = granted_q;
    region_d       = region_q;
    grant_offset_d = grant_offset_q;
    opened_d       = opened_q;
    opened_size_d  = opened_size_q;
    table_full_d   = table_full_q;
    wr             = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (operation_i == OP_RESET || request_size_i == '0) begin
            if (operation_i == OP_RESET) begin
              main_offset_d = '0;
              chunk_count_d = '0;
            end
            done_d         = 1'b1;
            granted_d      = 1'b0;
            region_d       = '0;
            grant_offset_d = '0;
            opened_d       = 1'b0;
            opened_size_d  = '0;
            table_full_d   = 1'b0;
          end else begin
            size_d  = request_size_i;
            mask_d  = (alignment_i == '0) ? DEFAULT_ALIGN_MASK : alignment_i - 32'd1;
            state_d = ST_MAIN_AL;
          end
        end
      end
      ST_MAIN_AL: begin
        al_d    = aligned;
        state_d = ST_MAIN_CK;
      end
      ST_MAIN_CK, ST_CH_CK: begin
        if (fit) begin
          if (state_q == ST_MAIN_CK) begin
            main_offset_d = fit_sum[31:0];
            region_d      = '0;
          end else begin
            wr.en          = 1'b1;
            wr.addr        = idx_q;
            wr.data.offset = fit_sum[31:0];
            wr.data.size   = rd_entry.size;
            region_d       = REGION_W'(CNT_W'(idx_q) + CNT_W'(1));
          end
          done_d         = 1'b1;
          granted_d      = 1'b1;
          grant_offset_d = al_q[31:0];
          opened_d       = 1'b0;
          opened_size_d  = '0;
          table_full_d   = 1'b0;
          state_d        = ST_IDLE;
        end else if (state_q == ST_MAIN_CK && chunk_count_q != '0) begin
          idx_d   = '0;
          state_d = ST_RD;
        end else if (state_q == ST_CH_CK && !last_chunk) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_RD;
        end else if (chunk_count_q == CNT_W'(MAX_CHUNKS)) begin
          done_d         = 1'b1;
          granted_d      = 1'b0;
          region_d       = '0;
          grant_offset_d = '0;
          opened_d       = 1'b0;
          opened_size_d  = '0;
          table_full_d   = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_OPEN;
        end
      end
      ST_RD: begin
        state_d = ST_CH_AL;
      end
      ST_CH_AL: begin
        al_d    = aligned;
        state_d = ST_CH_CK;
      end
      ST_OPEN: begin
        wr.en          = 1'b1;
        wr.addr        = chunk_count_q[IDX_W-1:0];
        wr.data.offset = size_q;
        wr.data.size   = cs;
        chunk_count_d  = count_inc;
        done_d         = 1'b1;
        granted_d      = 1'b1;
        region_d       = REGION_W'(count_inc);
        grant_offset_d = '0;
        opened_d       = 1'b1;
        opened_size_d  = cs;
        table_full_d   = 1'b0;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      main_offset_q <= '0;
      chunk_count_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      main_offset_q <= main_offset_d;
      chunk_count_q <= chunk_count_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q          <= idx_d;
    size_q         <= size_d;
    mask_q         <= mask_d;
    al_q           <= al_d;
    granted_q      <= granted_d;
    region_q       <= region_d;
    grant_offset_q <= grant_offset_d;
    opened_q       <= opened_d;
    opened_size_q  <= opened_size_d;
    table_full_q   <= table_full_d;
  end

  // Configuration register.
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BASE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_size_q <= DEFAULT_BASE;
    end else if (cfg_wr) begin
      base_size_q <= (pwdata == '0) ? DEFAULT_BASE : pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_BASE_SIZE) ? base_size_q : '0;
  assign pready = 1'b1;

  assign done_o         = done_q;
  assign granted_o      = granted_q;
  assign region_o       = region_q;
  assign grant_offset_o = grant_offset_q;
  assign opened_chunk_o = opened_q;
  assign opened_size_o  = opened_size_q;
  assign table_full_o   = table_full_q;

  `ABAO_ASSERT_SAME(a_grant_or_full, done_o, !(granted_o && table_full_o))
  `ABAO_ASSERT_NEXT(a_frame_reset, start && !busy && operation_i == OP_RESET,
                    done_o && !granted_o && chunk_count_q == '0 && main_offset_q == '0)
  `ABAO_ASSERT_SAME(a_count_bound, 1'b1, chunk_count_q <= CNT_W'(MAX_CHUNKS))
  `ABAO_ASSERT_SAME(a_open_region, done_o && opened_chunk_o,
                    granted_o && region_o == REGION_W'(chunk_count_q))
  `ABAO_ASSERT_SAME(a_done_idle, done_o, state_q == ST_IDLE)

endmodule

// ===== src/abao_chunk_mem.sv =====
// ----------------------------------------------------------------------------
// abao_chunk_mem
// Overflow chunk table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module abao_chunk_mem
  import abao_pkg::*;
(
  input  logic             clk_i,
  input  chunk_wr_t        wr_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output chunk_entry_t     rd_data_o
);

  chunk_entry_t mem_q [MAX_CHUNKS];
  chunk_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== tb/bump_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_alloc_checker
// Watches the request, result and APB channels of the bump allocator. It
// keeps its own copy of the allocator state, predicts the result of every
// accepted request beat and compares each result beat, field by field, with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module bump_alloc_checker
  import abao_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                operation_i,
  input  logic [31:0]         request_size_i,
  input  logic [31:0]         alignment_i,
  input  logic                done_i,
  input  logic                granted_i,
  input  logic [REGION_W-1:0] region_i,
  input  logic [31:0]         grant_offset_i,
  input  logic                opened_chunk_i,
  input  logic [31:0]         opened_size_i,
  input  logic                table_full_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  output int                  mismatch_cnt_o,
  output int                  pending_o,
  output int                  opened_cnt_o,
  output int                  full_cnt_o
);

  typedef struct packed {
    logic                granted;
    logic [REGION_W-1:0] region;
    logic [31:0]         offset;
    logic                opened;
    logic [31:0]         opened_size;
    logic                full;
  } alloc_result_t;

  // Shadow copy of the allocator state.
  logic [31:0]   cfg_base;
  logic [31:0]   main_off;
  int unsigned   n_chunks;
  logic [31:0]   chunk_off [MAX_CHUNKS];
  logic [31:0]   chunk_sz  [MAX_CHUNKS];

  alloc_result_t grant_q [$];
  alloc_result_t got_r;
  alloc_result_t exp_r;
  alloc_result_t new_r;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt_o < 50) begin
      $display("%0t ns: mismatch on %s: got 0x%08h, expected 0x%08h",
               $realtime, what, got, want);
    end
    mismatch_cnt_o++;
  endtask

  // Round v up with a low-bit mask; the carry lands in bit 32.
  function automatic logic [32:0] round_up(input logic [31:0] v, input logic [31:0] m);
    return ({1'b0, v} + {1'b0, m}) & ~{1'b0, m};
  endfunction

  function automatic bit fits(input logic [31:0] off, input logic [31:0] limit,
                              input logic [31:0] size, input logic [31:0] mask,
                              output logic [31:0] where_o, output logic [31:0] next_o);
    logic [32:0] al;
    logic [33:0] sum;
    al      = round_up(off, mask);
    sum     = {1'b0, al} + {2'b00, size};
    where_o = al[31:0];
    next_o  = sum[31:0];
    return sum <= {2'b00, limit};
  endfunction

  task automatic predict_grant(input op_e op, input logic [31:0] size,
                               input logic [31:0] align_in, output alloc_result_t r);
    logic [31:0] mask;
    logic [31:0] where;
    logic [31:0] next;
    logic [32:0] cs;
    bit          hit;
    int unsigned k;
    r = '0;
    if (op == OP_RESET) begin
      main_off = '0;
      n_chunks = 0;
    end else if (size != '0) begin
      mask = (align_in == '0) ? DEFAULT_ALIGN_MASK : align_in - 32'd1;
      if (fits(main_off, cfg_base, size, mask, where, next)) begin
        main_off  = next;
        r.granted = 1'b1;
        r.offset  = where;
      end else begin
        hit = 1'b0;
        // First fit over the open chunks, in the order they were opened.
        for (k = 0; k < n_chunks && !hit; k++) begin
          if (fits(chunk_off[k], chunk_sz[k], size, mask, where, next)) begin
            chunk_off[k] = next;
            hit          = 1'b1;
            r.granted    = 1'b1;
            r.region     = REGION_W'(k + 1);
            r.offset     = where;
          end
        end
        if (!hit) begin
          if (n_chunks >= MAX_CHUNKS) begin
            r.full = 1'b1;
          end else begin
            cs = round_up(size, CHUNK_GRAIN_MASK);
            if (cs < {1'b0, cfg_base}) cs = {1'b0, cfg_base};
            chunk_sz[n_chunks]  = cs[32] ? 32'hFFFF_FFFF : cs[31:0];
            chunk_off[n_chunks] = size;
            r.granted     = 1'b1;
            r.region      = REGION_W'(n_chunks + 1);
            r.opened      = 1'b1;
            r.opened_size = chunk_sz[n_chunks];
            n_chunks++;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base = DEFAULT_BASE;
      main_off = '0;
      n_chunks = 0;
      for (int k = 0; k < MAX_CHUNKS; k++) begin
        chunk_off[k] = '0;
        chunk_sz[k]  = '0;
      end
      grant_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      opened_cnt_o   = 0;
      full_cnt_o     = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_BASE_SIZE) begin
        if (pwrite_i) begin
          cfg_base = (pwdata_i == '0) ? DEFAULT_BASE : pwdata_i;
        end else if (prdata_i !== cfg_base) begin
          report_mismatch("base_size read", prdata_i, cfg_base);
        end
      end

      // A result beat is checked before a request beat taken on the same
      // edge is predicted, since it belongs to an older request.
      if (done_i) begin
        got_r = '{granted_i, region_i, grant_offset_i, opened_chunk_i,
                  opened_size_i, table_full_i};
        if (grant_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, '0);
        end else begin
          exp_r = grant_q.pop_front();
          if (got_r.granted !== exp_r.granted)
            report_mismatch("granted", 32'(got_r.granted), 32'(exp_r.granted));
          if (got_r.region !== exp_r.region)
            report_mismatch("region", 32'(got_r.region), 32'(exp_r.region));
          if (got_r.offset !== exp_r.offset)
            report_mismatch("grant_offset", got_r.offset, exp_r.offset);
          if (got_r.opened !== exp_r.opened)
            report_mismatch("opened_chunk", 32'(got_r.opened), 32'(exp_r.opened));
          if (got_r.opened_size !== exp_r.opened_size)
            report_mismatch("opened_size", got_r.opened_size, exp_r.opened_size);
          if (got_r.full !== exp_r.full)
            report_mismatch("table_full", 32'(got_r.full), 32'(exp_r.full));
        end
      end

      if (start_i && !busy_i) begin
        predict_grant(op_e'(operation_i), request_size_i, alignment_i, new_r);
        if (new_r.opened) opened_cnt_o++;
        if (new_r.full) full_cnt_o++;
        grant_q = {grant_q, new_r};
      end
      pending_o = grant_q.size();
    end
  end

endmodule

// ===== tb/tb_aligned_bump_allocator_with_overflow.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aligned_bump_allocator_with_overflow
// Drives directed and random request beats into the bump allocator over
// several base_size settings, with bursts and gaps on the request side, and
// takes the verdict from the checker that predicts every result.
// ----------------------------------------------------------------------------
module tb_aligned_bump_allocator_with_overflow;
  import abao_pkg::*;

  localparam int unsigned            N_PHASES        = 7;
  localparam int unsigned            ITEMS_PER_PHASE = 236;
  localparam int unsigned            DRAIN_CYCLES    = 40;
  localparam logic [PADDR_W-1:0]     BASE_SIZE_ADDR  = {REG_BASE_SIZE, 2'b00};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                operation;
  logic [31:0]         request_size;
  logic [31:0]         alignment;
  logic                done;
  logic                granted;
  logic [REGION_W-1:0] region;
  logic [31:0]         grant_offset;
  logic                opened_chunk;
  logic [31:0]         opened_size;
  logic                table_full;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int mismatch_cnt;
  int pending;
  int opened_cnt;
  int full_cnt;

  int          beats_sent;
  int          resets_sent;
  int          empty_sent;
  int          burst_left;
  int          frame_left;
  int unsigned pick;
  logic [31:0] base_plan [N_PHASES];
  logic [31:0] eff_base;
  logic [31:0] span;
  logic [31:0] sz;
  logic [31:0] al;
  op_e         op;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  aligned_bump_allocator_with_overflow u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation),
    .request_size_i (request_size),
    .alignment_i    (alignment),
    .done_o         (done),
    .granted_o      (granted),
    .region_o       (region),
    .grant_offset_o (grant_offset),
    .opened_chunk_o (opened_chunk),
    .opened_size_o  (opened_size),
    .table_full_o   (table_full),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  bump_alloc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .operation_i    (operation),
    .request_size_i (request_size),
    .alignment_i    (alignment),
    .done_i         (done),
    .granted_i      (granted),
    .region_i       (region),
    .grant_offset_i (grant_offset),
    .opened_chunk_i (opened_chunk),
    .opened_size_i  (opened_size),
    .table_full_i   (table_full),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .opened_cnt_o   (opened_cnt),
    .full_cnt_o     (full_cnt)
  );

  // Offers one request beat and returns on the edge that takes it. With
  // keep set, start stays high for the next beat.
  task automatic send_item(input op_e o, input logic [31:0] s, input logic [31:0] a,
                           input bit keep);
    start        <= 1'b1;
    operation    <= o;
    request_size <= s;
    alignment    <= a;
    do @(posedge clk_i); while (busy);
    beats_sent++;
    if (o == OP_RESET) resets_sent++;
    else if (s == '0) empty_sent++;
    if (!keep) start <= 1'b0;
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BASE_SIZE_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    operation    <= OP_ALLOC;
    request_size <= '0;
    alignment    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    beats_sent   = 0;
    resets_sent  = 0;
    empty_sent   = 0;
    burst_left   = 0;
    frame_left   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the default base_size of 1 MiB.
    send_item(OP_ALLOC, 32'd0,          32'd0,          1'b1);
    send_item(OP_RESET, 32'hFFFF_FFFF,  32'h8000_0000,  1'b1);
    send_item(OP_ALLOC, 32'd1,          32'd0,          1'b1);
    send_item(OP_ALLOC, 32'd1,          32'd1,          1'b1);
    send_item(OP_ALLOC, 32'd100,        32'd3,          1'b1);
    // Aligned offset far past the main region: opens the first chunk.
    send_item(OP_ALLOC, 32'd16,         32'h8000_0000,  1'b1);
    // The rounded chunk size saturates here.
    send_item(OP_ALLOC, 32'hFFFF_FFFF,  32'd0,          1'b1);
    repeat (6) send_item(OP_ALLOC, 32'h8000_0000, 32'd0, 1'b1);
    send_item(OP_ALLOC, 32'h8000_0000,  32'd0,          1'b1);
    send_item(OP_ALLOC, 32'h0000_0100,  32'h0000_0100,  1'b1);
    send_item(OP_ALLOC, 32'h0001_0000,  32'h0001_0000,  1'b1);
    send_item(OP_ALLOC, 32'h000F_FF00,  32'd0,          1'b1);
    // Aligning the saturated chunk's offset carries into bit 32.
    send_item(OP_ALLOC, 32'd1,          32'h8000_0000,  1'b1);
    send_item(OP_RESET, 32'd0,          32'd0,          1'b1);
    send_item(OP_ALLOC, 32'h0010_0000,  32'd0,          1'b1);
    send_item(OP_ALLOC, 32'd1,          32'd0,          1'b1);
    send_item(OP_ALLOC, 32'h0012_3457,  32'd0,          1'b1);
    send_item(OP_RESET, 32'h1234_5678,  32'd7,          1'b0);
    wait_idle();

    base_plan[0] = 32'hFFFF_FFFF;
    base_plan[1] = 32'd1;
    base_plan[2] = 32'd0;
    base_plan[3] = 32'h0000_1000;
    base_plan[4] = $urandom_range(1, 32'h0020_0000);
    base_plan[5] = 32'h0001_0000;
    base_plan[6] = $urandom();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      apb_access(1'b1, base_plan[ph]);
      apb_access(1'b0, '0);
      eff_base = (base_plan[ph] == '0) ? DEFAULT_BASE : base_plan[ph];
      span     = (eff_base >> 3 == 0) ? 32'd1 : eff_base >> 3;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;

        pick = $urandom_range(0, 19);
        if (pick == 0)       sz = '0;
        else if (pick <= 8)  sz = $urandom_range(1, 256);
        else if (pick <= 13) sz = $urandom_range(1, span);
        else if (pick <= 16) sz = $urandom_range(1, eff_base);
        else if (pick == 17) sz = 32'hFFFF_FFFF - $urandom_range(0, 255);
        else                 sz = $urandom();

        pick = $urandom_range(0, 19);
        if (pick <= 2)       al = '0;
        else if (pick <= 16) al = 32'd1 << $urandom_range(0, 8);
        else if (pick <= 18) al = 32'd1 << $urandom_range(9, 31);
        else                 al = $urandom_range(0, 32'h8000_0000);

        // Frames of random length, each closed by a reset beat whose other
        // fields carry noise.
        if (frame_left == 0) begin
          op         = OP_RESET;
          frame_left = $urandom_range(3, 60);
        end else begin
          op = OP_ALLOC;
          frame_left--;
        end

        send_item(op, sz, al, burst_left != 0 && n != ITEMS_PER_PHASE - 1);
        if (burst_left == 0 && n != ITEMS_PER_PHASE - 1) begin
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end
      end
      burst_left = 0;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    $display("Sent %0d request beats (%0d frame resets, %0d zero sizes) over %0d base_size settings.",
             beats_sent, resets_sent, empty_sent, N_PHASES + 1);
    $display("Predicted %0d chunk openings and %0d table-full results.", opened_cnt, full_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
